// File: rtl/core/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg: shared types and codes for the searchable stack
// Operation codes, status codes, the command word that passes from the front
// end to the execution unit, and the result word.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [2:0] {
    K_PUSH,
    K_POP,
    K_READ,
    K_SEARCH,
    K_CLEAR,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
    logic [6:0]         from_top;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic               found;
    logic [5:0]         position;
    logic [1:0]         status;
    logic [6:0]         count;
  } res_t;

endpackage

// File: rtl/core/lss_if.sv
// ----------------------------------------------------------------------------
// lss_if: handshake channels of the searchable stack
// One channel for operation words going in and one for result words going out.
// ----------------------------------------------------------------------------
interface lss_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] value;
  logic [6:0]         from_top;

  modport source (output valid, output op, output value, output from_top, input ready);
  modport sink (input valid, input op, input value, input from_top, output ready);
endinterface

interface lss_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data;
  logic               found;
  logic [5:0]         position;
  logic [1:0]         status;
  logic [6:0]         count;

  modport source (
    output valid, output data, output found, output position, output status,
    output count, input ready
  );
  modport sink (
    input valid, input data, input found, input position, input status,
    input count, output ready
  );
endinterface

// File: rtl/core/lifo_stack_with_search.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search: stack of signed words with a value search
// Push, pop, read from the top, search among the live entries and clear.
//
//   channel  | dir | handshake     | word
//   ---------+-----+---------------+----------------------------------------
//   item     | in  | valid / ready | op, value, from_top
//   result   | out | valid / ready | data, found, position, status, count
//
// Push, clear, unused codes and rejected operations complete in the idle
// state of the execution unit; pop and read pass through the read state for
// the registered memory read. A search of a non-empty stack compares the
// live entries one at a time from the bottom up and stops at the first match.
// Reset clears the fill count and all handshake state; the entry memory is
// not cleared. A two-entry command queue lets intake run ahead of execution,
// and a stalled result holds its word while the next command waits.
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
  parameter int DEPTH = lss_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  lss_in_if.sink    item,
  lss_out_if.source result
);

  logic          f_valid;
  logic          f_ready;
  lss_pkg::cmd_t f_cmd;
  logic          q_valid;
  logic          q_ready;
  lss_pkg::cmd_t q_cmd;

  lss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  lss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  lss_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .result    (result)
  );

endmodule

// File: rtl/core/lss_front.sv
// ----------------------------------------------------------------------------
// lss_front: operation intake
// Accepts operation words, decodes the operation code into a command kind and
// holds the command until the queue takes it.
// ----------------------------------------------------------------------------
module lss_front (
  input  logic             clk,
  input  logic             rst,
  lss_in_if.sink           item,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output lss_pkg::cmd_t    cmd
);

  logic          vld;
  lss_pkg::cmd_t hold;
  lss_pkg::kind_t kind;

  always_comb begin
    case (item.op)
      lss_pkg::OP_PUSH:   kind = lss_pkg::K_PUSH;
      lss_pkg::OP_POP:    kind = lss_pkg::K_POP;
      lss_pkg::OP_READ:   kind = lss_pkg::K_READ;
      lss_pkg::OP_SEARCH: kind = lss_pkg::K_SEARCH;
      lss_pkg::OP_CLEAR:  kind = lss_pkg::K_CLEAR;
      default:            kind = lss_pkg::K_NOP;
    endcase
  end

  assign item.ready = !vld || cmd_ready;
  assign cmd_valid  = vld;
  assign cmd        = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (item.valid && item.ready) begin
      vld <= 1'b1;
    end else if (cmd_ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      hold.kind     <= kind;
      hold.value    <= item.value;
      hold.from_top <= item.from_top;
    end
  end

endmodule

// File: rtl/core/lss_queue.sv
// ----------------------------------------------------------------------------
// lss_queue: two-entry command queue
// Decouples the intake from the execution unit so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module lss_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lss_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output lss_pkg::cmd_t out_cmd
);

  lss_pkg::cmd_t slot [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic          push;
  logic          pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_cmd   = slot[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= in_cmd;
    end
  end

endmodule

// File: rtl/core/lss_back.sv
// ----------------------------------------------------------------------------
// lss_back: stack execution unit
// Holds the entry memory and the fill count, carries out one command at a
// time, walks the live entries for a search and registers each result word.
// ----------------------------------------------------------------------------
module lss_back #(
  parameter int DEPTH = lss_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  lss_pkg::cmd_t cmd,
  lss_out_if.source     result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > 7) ? FW : 7;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [FW-1:0]      fill;
  logic [FW-1:0]      fill_next;
  logic [AW-1:0]      sidx;
  logic [AW-1:0]      sidx_next;
  logic signed [31:0] key;
  logic signed [31:0] key_next;

  logic               o_valid;
  lss_pkg::res_t      res;
  lss_pkg::res_t      res_next;
  logic               load;
  logic               out_free;

  logic [FW-1:0]      fill_m1;
  logic [CW-1:0]      fill_w;
  logic [CW-1:0]      nth_w;
  logic [CW-1:0]      diff_w;
  logic [CW-1:0]      cnt_w;
  logic [CW-1:0]      pos_w;
  logic [FW-1:0]      sidx_p1;

  assign out_free  = !o_valid || result.ready;
  assign cmd_ready = (state == S_IDLE) && out_free;

  assign fill_m1 = fill - 1'b1;
  assign fill_w  = CW'(fill);
  assign nth_w   = CW'(cmd.from_top);
  assign diff_w  = fill_w - nth_w;
  assign sidx_p1 = FW'(sidx) + 1'b1;
  assign pos_w   = CW'(sidx);

  always_comb begin
    state_next = state;
    fill_next  = fill;
    sidx_next  = sidx;
    key_next   = key;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    load       = 1'b0;
    res_next   = '0;
    res_next.status = lss_pkg::ST_OK;

    case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          case (cmd.kind)
            lss_pkg::K_PUSH: begin
              load = 1'b1;
              if (fill >= FW'(DEPTH)) begin
                res_next.status = lss_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                fill_next = fill + 1'b1;
              end
            end
            lss_pkg::K_POP: begin
              if (fill == '0) begin
                load            = 1'b1;
                res_next.status = lss_pkg::ST_EMPTY;
              end else begin
                fill_next  = fill_m1;
                rd_en      = 1'b1;
                rd_addr    = fill_m1[AW-1:0];
                state_next = S_READ;
              end
            end
            lss_pkg::K_READ: begin
              if (fill == '0) begin
                load            = 1'b1;
                res_next.status = lss_pkg::ST_EMPTY;
              end else if (nth_w == '0 || nth_w > fill_w) begin
                load            = 1'b1;
                res_next.status = lss_pkg::ST_RANGE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = diff_w[AW-1:0];
                state_next = S_READ;
              end
            end
            lss_pkg::K_SEARCH: begin
              key_next = cmd.value;
              if (fill == '0) begin
                load = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                sidx_next  = '0;
                state_next = S_SEARCH;
              end
            end
            lss_pkg::K_CLEAR: begin
              load      = 1'b1;
              fill_next = '0;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load          = 1'b1;
          res_next.data = rdata;
          state_next    = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (out_free) begin
          if (rdata == key) begin
            load              = 1'b1;
            res_next.found    = 1'b1;
            res_next.position = pos_w[5:0];
            state_next        = S_IDLE;
          end else if (sidx_p1 == fill) begin
            load       = 1'b1;
            state_next = S_IDLE;
          end else begin
            sidx_next = sidx_p1[AW-1:0];
            rd_en     = 1'b1;
            rd_addr   = sidx_p1[AW-1:0];
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    cnt_w          = CW'(fill_next);
    res_next.count = cnt_w[6:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill[AW-1:0]] <= cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (load) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sidx <= sidx_next;
    key  <= key_next;
    if (load) begin
      res <= res_next;
    end
  end

  assign result.valid    = o_valid;
  assign result.data     = res.data;
  assign result.found    = res.found;
  assign result.position = res.position;
  assign result.status   = res.status;
  assign result.count    = res.count;

endmodule
